@@ sv/wfm_pkg.sv @@
package wfm_pkg;

  // Frame and sample geometry
  localparam int FrameLen  = 2048;
  localparam int IdxW      = $clog2(FrameLen);
  localparam int SampleW   = 12;
  localparam int FracW     = 8;
  localparam int MeanW     = SampleW + FracW;
  localparam int SumW      = 24;
  localparam int CountW    = IdxW + 1;
  localparam int DividendW = SumW + FracW;
  localparam int DivCntW   = $clog2(DividendW);

  // Configuration register map
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;
  localparam logic [CfgIdxW-1:0] CFG_MEASURE_EN   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_START = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_END   = 2'd2;

  localparam int WinStartW = 11;
  localparam int WinEndW   = 12;
  localparam logic [WinStartW-1:0] WIN_START_RST = WinStartW'(50);
  localparam logic [WinEndW-1:0]   WIN_END_RST   = WinEndW'(2000);

  // Stream payload widths
  localparam int InDataW  = 16;
  localparam int OutDataW = 72;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_PUSH
  } wfm_state_e;

  typedef struct packed {
    logic accept;     // sample request taken this cycle
    logic div_step;   // one restoring-division step
    logic load_out;   // move results into the output register
  } wfm_cmd_t;

  typedef struct packed {
    logic last_sample;  // current index is the last of the frame
    logic measure_en;
  } wfm_status_t;

endpackage

@@ sv/waveform_frame_measurement.sv @@
// Waveform frame measurement. ADC samples (12-bit codes, low bits of
// s_axis_tdata_i) are counted into frames of 2048. Samples whose frame index
// lies in [window_start, window_end) are summed and tracked for min/max, and
// the first two rising crossings of the previous measured frame's mean are
// recorded. When a frame closes with measure_enable set, one result request
// goes out: mean (8 fraction bits, truncated), max, min, peak-to-peak and
// period with its valid flag in tuser; that mean becomes the next crossing
// threshold. With measure_enable clear the frame is dropped silently.
// Rate: one sample per clock. After the last sample of a measured frame the
// input stalls while the 32-step restoring divider forms the mean and the
// output register is loaded, and longer while the previous result still
// waits on m_axis_tready_i. An empty window reports mean 0, min 4095.
// Config writes (cfg_we_i) are meant for idle periods: index 0 enable,
// 1 window_start, 2 window_end.
module waveform_frame_measurement (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [wfm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [wfm_pkg::CfgDataW-1:0]   cfg_data_i,
  // sample stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [wfm_pkg::InDataW-1:0]    s_axis_tdata_i,   // [11:0] sample
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [19:0] mean_fixed, [31:20] max_code, [43:32] min_code,
  // [55:44] peak_to_peak, [66:56] period_samples, rest zero
  output logic [wfm_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                           m_axis_tuser_o    // period_valid
);

  wfm_pkg::wfm_cmd_t    cmd;
  wfm_pkg::wfm_status_t status;

  logic [wfm_pkg::MeanW-1:0]   mean;
  logic [wfm_pkg::SampleW-1:0] max_code, min_code, p2p;
  logic [wfm_pkg::IdxW-1:0]    period;

  wfm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  wfm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (s_axis_tdata_i[wfm_pkg::SampleW-1:0]),
    .cmd_i          (cmd),
    .status_o       (status),
    .mean_o         (mean),
    .max_o          (max_code),
    .min_o          (min_code),
    .p2p_o          (p2p),
    .period_o       (period),
    .period_valid_o (m_axis_tuser_o)
  );

  // Pack result fields, lowest field first, zero pad to whole bytes
  assign m_axis_tdata_o = wfm_pkg::OutDataW'({period, p2p, min_code, max_code, mean});

endmodule

@@ sv/wfm_ctrl.sv @@
module wfm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  input  wfm_pkg::wfm_status_t status_i,
  output wfm_pkg::wfm_cmd_t    cmd_o
);

  wfm_pkg::wfm_state_e state_q, state_d;
  logic [wfm_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wfm_pkg::ST_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    s_ready_o       = 1'b0;
    cmd_o           = '0;
    out_valid_d     = out_valid_q && !m_ready_i;
    unique case (state_q)
      wfm_pkg::ST_RUN: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
        cnt_d        = '0;
        if (s_valid_i && status_i.last_sample && status_i.measure_en) begin
          state_d = wfm_pkg::ST_DIV;
        end
      end
      wfm_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == wfm_pkg::DivCntW'(wfm_pkg::DividendW - 1)) begin
          state_d = wfm_pkg::ST_PUSH;
        end
      end
      wfm_pkg::ST_PUSH: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = wfm_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = wfm_pkg::ST_RUN;
      end
    endcase
  end

  assign m_valid_o = out_valid_q;

endmodule

@@ sv/wfm_datapath.sv @@
module wfm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wfm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wfm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [wfm_pkg::SampleW-1:0]   sample_i,
  input  wfm_pkg::wfm_cmd_t             cmd_i,
  output wfm_pkg::wfm_status_t          status_o,
  output logic [wfm_pkg::MeanW-1:0]     mean_o,
  output logic [wfm_pkg::SampleW-1:0]   max_o,
  output logic [wfm_pkg::SampleW-1:0]   min_o,
  output logic [wfm_pkg::SampleW-1:0]   p2p_o,
  output logic [wfm_pkg::IdxW-1:0]      period_o,
  output logic                          period_valid_o
);

  localparam logic [wfm_pkg::IdxW-1:0] LastIdx = wfm_pkg::IdxW'(wfm_pkg::FrameLen - 1);
  localparam logic [wfm_pkg::SampleW-1:0] CodeMax = '1;

  // Configuration
  logic                            en_q;
  logic [wfm_pkg::WinStartW-1:0]   win_start_q;
  logic [wfm_pkg::WinEndW-1:0]     win_end_q;

  // Frame accumulators
  logic [wfm_pkg::IdxW-1:0]    idx_q;
  logic [wfm_pkg::SampleW-1:0] prev_q;
  logic [wfm_pkg::SumW-1:0]    sum_q, sum_d;
  logic [wfm_pkg::CountW-1:0]  cnt_q, cnt_d;
  logic [wfm_pkg::SampleW-1:0] max_q, max_d, min_q, min_d;
  logic [1:0]                  xfound_q, xfound_d;
  logic [wfm_pkg::IdxW-1:0]    first_q, first_d, second_q, second_d;
  logic [wfm_pkg::MeanW-1:0]   thr_q;

  // Frame-end snapshot and divider
  logic [wfm_pkg::DividendW-1:0] dq_q;
  logic [wfm_pkg::CountW-1:0]    rem_q, divisor_q;
  logic                          zero_q;
  logic [wfm_pkg::SampleW-1:0]   smax_q, smin_q;
  logic [wfm_pkg::IdxW-1:0]      speriod_q;
  logic                          svalid_q;

  // Output register
  logic [wfm_pkg::MeanW-1:0]   omean_q;
  logic [wfm_pkg::SampleW-1:0] omax_q, omin_q, op2p_q;
  logic [wfm_pkg::IdxW-1:0]    operiod_q;
  logic                        ovalid_q;

  logic in_win, rise, last;
  logic [wfm_pkg::CountW:0] rem_ext;
  logic                     ge;
  logic [wfm_pkg::MeanW-1:0] mean_w;

  assign last = (idx_q == LastIdx);
  assign status_o.last_sample = last;
  assign status_o.measure_en  = en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      win_start_q <= wfm_pkg::WIN_START_RST;
      win_end_q   <= wfm_pkg::WIN_END_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wfm_pkg::CFG_MEASURE_EN:   en_q        <= cfg_data_i[0];
        wfm_pkg::CFG_WINDOW_START: win_start_q <= cfg_data_i[wfm_pkg::WinStartW-1:0];
        wfm_pkg::CFG_WINDOW_END:   win_end_q   <= cfg_data_i[wfm_pkg::WinEndW-1:0];
        default: ;
      endcase
    end
  end

  // Per-sample window update
  always_comb begin
    in_win = ({1'b0, idx_q} >= {1'b0, win_start_q}) && ({1'b0, idx_q} < win_end_q);
    rise   = in_win && ({sample_i, {wfm_pkg::FracW{1'b0}}} > thr_q)
                    && ({prev_q, {wfm_pkg::FracW{1'b0}}} <= thr_q);
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    max_d    = max_q;
    min_d    = min_q;
    xfound_d = xfound_q;
    first_d  = first_q;
    second_d = second_q;
    if (in_win) begin
      sum_d = sum_q + wfm_pkg::SumW'(sample_i);
      cnt_d = cnt_q + 1'b1;
      if (sample_i > max_q) max_d = sample_i;
      if (sample_i < min_q) min_d = sample_i;
    end
    if (rise) begin
      if (xfound_q == 2'd0) begin
        first_d  = idx_q;
        xfound_d = 2'd1;
      end else if (xfound_q == 2'd1) begin
        second_d = idx_q;
        xfound_d = 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      prev_q   <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      max_q    <= '0;
      min_q    <= CodeMax;
      xfound_q <= '0;
      first_q  <= '0;
      second_q <= '0;
    end else if (cmd_i.accept) begin
      prev_q <= sample_i;
      if (last) begin
        idx_q    <= '0;
        sum_q    <= '0;
        cnt_q    <= '0;
        max_q    <= '0;
        min_q    <= CodeMax;
        xfound_q <= '0;
        first_q  <= '0;
        second_q <= '0;
      end else begin
        idx_q    <= idx_q + 1'b1;
        sum_q    <= sum_d;
        cnt_q    <= cnt_d;
        max_q    <= max_d;
        min_q    <= min_d;
        xfound_q <= xfound_d;
        first_q  <= first_d;
        second_q <= second_d;
      end
    end
  end

  // Restoring divider: one quotient bit per step, quotient shifts into dq_q
  assign rem_ext = {rem_q, dq_q[wfm_pkg::DividendW-1]};
  assign ge      = rem_ext >= {1'b0, divisor_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && last) begin
      dq_q      <= {sum_d, {wfm_pkg::FracW{1'b0}}};
      rem_q     <= '0;
      divisor_q <= cnt_d;
      zero_q    <= (cnt_d == '0);
      smax_q    <= max_d;
      smin_q    <= min_d;
      svalid_q  <= (xfound_d == 2'd2);
      speriod_q <= (xfound_d == 2'd2) ? (second_d - first_d) : '0;
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[wfm_pkg::DividendW-2:0], ge};
      rem_q <= ge ? wfm_pkg::CountW'(rem_ext - {1'b0, divisor_q})
                  : rem_ext[wfm_pkg::CountW-1:0];
    end
  end

  assign mean_w = zero_q ? '0 : dq_q[wfm_pkg::MeanW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cmd_i.load_out) begin
      thr_q <= mean_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      omean_q   <= mean_w;
      omax_q    <= smax_q;
      omin_q    <= smin_q;
      op2p_q    <= (smax_q >= smin_q) ? (smax_q - smin_q) : '0;
      operiod_q <= speriod_q;
      ovalid_q  <= svalid_q;
    end
  end

  assign mean_o         = omean_q;
  assign max_o          = omax_q;
  assign min_o          = omin_q;
  assign p2p_o          = op2p_q;
  assign period_o       = operiod_q;
  assign period_valid_o = ovalid_q;

endmodule
